@@ rtl/core/trn_pkg.sv @@
// Shared types and constants for the telnet receive negotiator.
`default_nettype none

package trn_pkg;

  // Highest option code classed as in range (OPT_OTHER_IN); codes above it are OPT_OUT.
  localparam int unsigned HIGHEST_OPTION = 35;

  // Front-to-back queue depth and derived widths
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // Telnet command bytes
  localparam logic [7:0] C_IAC  = 8'd255;
  localparam logic [7:0] C_DONT = 8'd254;
  localparam logic [7:0] C_DO   = 8'd253;
  localparam logic [7:0] C_WONT = 8'd252;
  localparam logic [7:0] C_WILL = 8'd251;
  localparam logic [7:0] C_SB   = 8'd250;
  localparam logic [7:0] C_DM   = 8'd242;
  localparam logic [7:0] C_SE   = 8'd240;

  // Option codes we act on
  localparam logic [7:0] O_BINARY = 8'd0;
  localparam logic [7:0] O_ECHO   = 8'd1;
  localparam logic [7:0] O_SGA    = 8'd3;
  localparam logic [7:0] O_TTYPE  = 8'd24;
  localparam logic [7:0] O_LFLOW  = 8'd33;

  // Subnegotiation values
  localparam logic [7:0] SUB_VAL_ZERO = 8'd0;
  localparam logic [7:0] SUB_VAL_ONE  = 8'd1;

  // Answer verbs
  localparam logic [1:0] V_WILL = 2'd0;
  localparam logic [1:0] V_WONT = 2'd1;
  localparam logic [1:0] V_DO   = 2'd2;
  localparam logic [1:0] V_DONT = 2'd3;

  // Command class of a byte when seen after IAC
  typedef enum logic [3:0] {
    CMD_IAC,
    CMD_DONT,
    CMD_DO,
    CMD_WONT,
    CMD_WILL,
    CMD_SB,
    CMD_DM,
    CMD_SE,
    CMD_OTHER
  } cmd_t;

  // Option class of a byte when seen as an option code
  typedef enum logic [2:0] {
    OPT_BINARY,
    OPT_ECHO,
    OPT_SGA,
    OPT_TTYPE,
    OPT_LFLOW,
    OPT_OTHER_IN,
    OPT_OUT
  } opt_t;

  // One classified byte travelling from front to back
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       urgent;
    cmd_t       cmd;
    opt_t       opt;
  } item_t;

endpackage

`default_nettype wire

@@ rtl/core/telnet_receive_negotiator.sv @@
// Top level of the telnet receive negotiator: front, queue and back end.
//
//  channel | handshake            | payload
//  --------+----------------------+-----------------------------------------
//  in      | in_valid / in_ready  | rx_byte, in_urgent
//  out     | out_valid / out_ready| term_*, reply_*, type_request, mode_update,
//          |                      | remote_echo, flow_on, suppressing
//  cfg     | cfg_valid / cfg_ready| deny_echo
//
// One byte per cycle sustained while out_ready holds; a byte is queued at its input
// transfer and moves from the queue into the result register when the back end pops it.
// The back end's combinational per-byte state update sets the rate.
// While the result register stalls, the two-entry queue takes two more bytes
// before in_ready drops.
// Synchronous reset clears parse state, flags, levels and the queue.
`default_nettype none

module telnet_receive_negotiator import trn_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] rx_byte,
  input  wire logic       in_urgent,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            term_valid,
  output logic [7:0]      term_byte,
  output logic            reply_valid,
  output logic [1:0]      reply_verb,
  output logic [7:0]      reply_option,
  output logic            type_request,
  output logic            mode_update,
  output logic            remote_echo,
  output logic            flow_on,
  output logic            suppressing,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic       deny_echo
);

  logic  q_valid;
  logic  q_ready;
  item_t q_item;

  // Config register is always writable
  assign cfg_ready = 1'b1;

  trn_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .rx_byte   (rx_byte),
    .in_urgent (in_urgent),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item)
  );

  trn_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_data     (deny_echo),
    .q_valid      (q_valid),
    .q_ready      (q_ready),
    .q_item       (q_item),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .term_valid   (term_valid),
    .term_byte    (term_byte),
    .reply_valid  (reply_valid),
    .reply_verb   (reply_verb),
    .reply_option (reply_option),
    .type_request (type_request),
    .mode_update  (mode_update),
    .remote_echo  (remote_echo),
    .flow_on      (flow_on),
    .suppressing  (suppressing)
  );

`ifndef ASSERT_OFF
  // Terminal data never leaves while output is suppressed
  a_no_data_when_suppressed: assert property (@(posedge clk) disable iff (rst)
    out_valid && term_valid |-> !suppressing)
    else $error("terminal byte delivered while suppressing");

  // A data byte and a negotiation answer never come from the same byte
  a_term_reply_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid && reply_valid |-> !term_valid)
    else $error("data byte and answer in one result");

  // Subnegotiation close gives either a type request or a mode update
  a_type_mode_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid && type_request |-> !mode_update && !reply_valid)
    else $error("type request combined with other action");

  // No result is presented right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid right after reset");
`endif

endmodule

`default_nettype wire

@@ rtl/core/trn_front.sv @@
// Front end: byte classification and a two-entry queue to the back end.
`default_nettype none

module trn_front import trn_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] rx_byte,
  input  wire logic       in_urgent,
  output logic            q_valid,
  input  wire logic       q_ready,
  output item_t           q_item
);

  item_t             cls_item;
  item_t             qmem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;
  logic              pop;

  // Classify the incoming byte both as command and as option code
  always_comb begin
    cls_item.rx_byte = rx_byte;
    cls_item.urgent  = in_urgent;
    unique case (rx_byte)
      C_IAC:   cls_item.cmd = CMD_IAC;
      C_DONT:  cls_item.cmd = CMD_DONT;
      C_DO:    cls_item.cmd = CMD_DO;
      C_WONT:  cls_item.cmd = CMD_WONT;
      C_WILL:  cls_item.cmd = CMD_WILL;
      C_SB:    cls_item.cmd = CMD_SB;
      C_DM:    cls_item.cmd = CMD_DM;
      C_SE:    cls_item.cmd = CMD_SE;
      default: cls_item.cmd = CMD_OTHER;
    endcase
    unique case (rx_byte)
      O_BINARY: cls_item.opt = OPT_BINARY;
      O_ECHO:   cls_item.opt = OPT_ECHO;
      O_SGA:    cls_item.opt = OPT_SGA;
      O_TTYPE:  cls_item.opt = OPT_TTYPE;
      O_LFLOW:  cls_item.opt = OPT_LFLOW;
      default: begin
        if (rx_byte <= 8'(HIGHEST_OPTION)) cls_item.opt = OPT_OTHER_IN;
        else cls_item.opt = OPT_OUT;
      end
    endcase
  end

  // Queue handshake
  assign in_ready = (count != QCNT_W'(QDEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != '0);
  assign pop      = q_valid && q_ready;
  assign q_item   = qmem[rd_ptr];

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      qmem[wr_ptr] <= cls_item;
    end
  end

  // Queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/trn_back.sv @@
// Back end: parse state, option negotiation and the result register.
`default_nettype none

module trn_back import trn_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_valid,
  input  wire logic       cfg_data,
  input  wire logic       q_valid,
  output logic            q_ready,
  input  wire item_t      q_item,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            term_valid,
  output logic [7:0]      term_byte,
  output logic            reply_valid,
  output logic [1:0]      reply_verb,
  output logic [7:0]      reply_option,
  output logic            type_request,
  output logic            mode_update,
  output logic            remote_echo,
  output logic            flow_on,
  output logic            suppressing
);

  typedef enum logic [2:0] {
    P_DATA, P_IAC, P_WILL, P_WONT, P_DO, P_DONT, P_SB, P_SE
  } pstate_t;

  // Only these flags can ever be set; all other option flags stay zero.
  typedef struct packed {
    logic rem_binary;
    logic rem_echo;
    logic rem_sga;
    logic loc_ttype;
    logic loc_lflow;
  } flags_t;

  pstate_t    state, state_next;
  flags_t     flags, flags_next;
  logic       flow, flow_next;
  logic [1:0] lvl, lvl_next;
  logic [1:0] sub_count, sub_count_next;
  logic [7:0] sub_option, sub_option_next;
  logic [7:0] sub_value, sub_value_next;
  logic       deny_echo;

  logic       r_term_v, r_rep_v, r_type, r_mode;
  logic [7:0] r_term_b, r_rep_opt;
  logic [1:0] r_rep_verb;
  logic       pop;
  logic       rem_set, loc_set, do_finish, do_after_iac, do_gather;
  logic [7:0] c;

  assign q_ready = !out_valid || out_ready;
  assign pop     = q_valid && q_ready;
  assign c       = q_item.rx_byte;

  // Current flag for the option byte
  always_comb begin
    case (q_item.opt)
      OPT_BINARY: rem_set = flags.rem_binary;
      OPT_ECHO:   rem_set = flags.rem_echo;
      OPT_SGA:    rem_set = flags.rem_sga;
      default:    rem_set = 1'b0;
    endcase
    case (q_item.opt)
      OPT_TTYPE: loc_set = flags.loc_ttype;
      OPT_LFLOW: loc_set = flags.loc_lflow;
      default:   loc_set = 1'b0;
    endcase
  end

  // Per-byte state update
  always_comb begin
    state_next      = state;
    flags_next      = flags;
    flow_next       = flow;
    sub_count_next  = sub_count;
    sub_option_next = sub_option;
    sub_value_next  = sub_value;
    r_term_v   = 1'b0;
    r_term_b   = 8'd0;
    r_rep_v    = 1'b0;
    r_rep_verb = V_WILL;
    r_rep_opt  = 8'd0;
    r_type     = 1'b0;
    r_mode     = 1'b0;
    do_finish    = 1'b0;
    do_after_iac = 1'b0;
    do_gather    = 1'b0;

    // urgent data raises suppression, leaving it drops one level
    if (q_item.urgent) lvl_next = 2'd2;
    else if (lvl == 2'd2) lvl_next = 2'd1;
    else lvl_next = lvl;

    unique case (state)
      P_DATA: begin
        if (q_item.cmd == CMD_IAC) begin
          state_next = P_IAC;
        end else if (lvl_next == 2'd0) begin
          r_term_v = 1'b1;
          r_term_b = c;
        end
      end
      P_IAC: do_after_iac = 1'b1;
      P_WILL: begin
        state_next = P_DATA;
        if (q_item.opt inside {OPT_BINARY, OPT_ECHO, OPT_SGA}) begin
          if (!rem_set) begin
            r_rep_v   = 1'b1;
            r_rep_opt = c;
            if (q_item.opt == OPT_ECHO && deny_echo) begin
              r_rep_verb = V_DONT;
            end else begin
              r_rep_verb = V_DO;
              case (q_item.opt)
                OPT_BINARY: flags_next.rem_binary = 1'b1;
                OPT_ECHO:   flags_next.rem_echo   = 1'b1;
                default:    flags_next.rem_sga    = 1'b1;
              endcase
              if (q_item.opt == OPT_ECHO) r_mode = 1'b1;
            end
          end
        end else begin
          r_rep_v    = 1'b1;
          r_rep_verb = V_DONT;
          r_rep_opt  = c;
        end
      end
      P_WONT: begin
        state_next = P_DATA;
        if (q_item.opt == OPT_OUT || rem_set) begin
          r_rep_v    = 1'b1;
          r_rep_verb = V_DONT;
          r_rep_opt  = c;
        end
        if (rem_set) begin
          case (q_item.opt)
            OPT_BINARY: flags_next.rem_binary = 1'b0;
            OPT_ECHO:   flags_next.rem_echo   = 1'b0;
            default:    flags_next.rem_sga    = 1'b0;
          endcase
          if (q_item.opt == OPT_ECHO) r_mode = 1'b1;
        end
      end
      P_DO: begin
        state_next = P_DATA;
        if (q_item.opt inside {OPT_TTYPE, OPT_LFLOW}) begin
          if (!loc_set) begin
            r_rep_v    = 1'b1;
            r_rep_verb = V_WILL;
            r_rep_opt  = c;
            if (q_item.opt == OPT_LFLOW) begin
              flags_next.loc_lflow = 1'b1;
              flow_next            = 1'b1;
              r_mode               = 1'b1;
            end else begin
              flags_next.loc_ttype = 1'b1;
            end
          end
        end else begin
          r_rep_v    = 1'b1;
          r_rep_verb = V_WONT;
          r_rep_opt  = c;
        end
      end
      P_DONT: begin
        state_next = P_DATA;
        if (q_item.opt == OPT_OUT || loc_set) begin
          r_rep_v    = 1'b1;
          r_rep_verb = V_WONT;
          r_rep_opt  = c;
        end
        if (loc_set) begin
          if (q_item.opt == OPT_LFLOW) flags_next.loc_lflow = 1'b0;
          else flags_next.loc_ttype = 1'b0;
        end
      end
      P_SB: begin
        if (q_item.cmd == CMD_IAC) state_next = P_SE;
        else do_gather = 1'b1;
      end
      P_SE: begin
        if (q_item.cmd == CMD_SE) begin
          do_finish  = 1'b1;
          state_next = P_DATA;
        end else if (q_item.cmd == CMD_IAC) begin
          do_gather  = 1'b1;
          state_next = P_SB;
        end else begin
          // truncated subnegotiation: close it, then treat byte as command
          do_finish    = 1'b1;
          do_after_iac = 1'b1;
        end
      end
      default: state_next = P_DATA;
    endcase

    // gather one subnegotiation byte
    if (do_gather) begin
      if (sub_count == 2'd0) sub_option_next = c;
      else if (sub_count == 2'd1) sub_value_next = c;
      if (sub_count != 2'd2) sub_count_next = sub_count + 2'd1;
    end

    // close the subnegotiation
    if (do_finish && sub_count == 2'd2) begin
      if (sub_option == O_LFLOW) begin
        if (flags.loc_lflow) begin
          if (sub_value == SUB_VAL_ONE) begin
            flow_next = 1'b1;
            r_mode    = 1'b1;
          end else if (sub_value == SUB_VAL_ZERO) begin
            flow_next = 1'b0;
            r_mode    = 1'b1;
          end
        end
      end else if (sub_option == O_TTYPE) begin
        if (flags.loc_ttype && sub_value == SUB_VAL_ONE) r_type = 1'b1;
      end
    end

    // command byte following IAC
    if (do_after_iac) begin
      state_next = P_DATA;
      unique case (q_item.cmd)
        CMD_WILL: state_next = P_WILL;
        CMD_WONT: state_next = P_WONT;
        CMD_DO:   state_next = P_DO;
        CMD_DONT: state_next = P_DONT;
        CMD_DM:   if (lvl_next == 2'd1) lvl_next = 2'd0;
        CMD_SB: begin
          sub_count_next  = 2'd0;
          sub_option_next = 8'd0;
          sub_value_next  = 8'd0;
          state_next      = P_SB;
        end
        CMD_IAC: begin
          if (lvl_next == 2'd0) begin
            r_term_v = 1'b1;
            r_term_b = c;
          end
        end
        default: state_next = P_DATA;
      endcase
    end
  end

  // State, config register and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= P_DATA;
      flags      <= '0;
      flow       <= 1'b0;
      lvl        <= 2'd0;
      sub_count  <= 2'd0;
      sub_option <= 8'd0;
      sub_value  <= 8'd0;
      deny_echo  <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_valid) deny_echo <= cfg_data;
      if (pop) begin
        state      <= state_next;
        flags      <= flags_next;
        flow       <= flow_next;
        lvl        <= lvl_next;
        sub_count  <= sub_count_next;
        sub_option <= sub_option_next;
        sub_value  <= sub_value_next;
        out_valid  <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    if (pop) begin
      term_valid   <= r_term_v;
      term_byte    <= r_term_b;
      reply_valid  <= r_rep_v;
      reply_verb   <= r_rep_verb;
      reply_option <= r_rep_opt;
      type_request <= r_type;
      mode_update  <= r_mode;
      remote_echo  <= flags_next.rem_echo;
      flow_on      <= flow_next;
      suppressing  <= (lvl_next != 2'd0);
    end
  end

endmodule

`default_nettype wire
